// ----- rtl/core/bhr_pkg.sv -----
// Shared types and codes for the button hold and auto-repeat event block.
package bhr_pkg;

   // Operation codes carried in req_tuser
   localparam logic [1:0] OP_SAMPLE  = 2'd0;
   localparam logic [1:0] OP_INHIBIT = 2'd1;
   localparam logic [1:0] OP_STARTUP = 2'd2;

   // Button identifiers; none marks a free owner slot
   localparam logic [2:0] BTN_NONE   = 3'd0;
   localparam logic [2:0] BTN_SELECT = 3'd1;
   localparam logic [2:0] BTN_ALT    = 3'd2;
   localparam logic [2:0] BTN_UP     = 3'd3;
   localparam logic [2:0] BTN_DOWN   = 3'd4;

   // Event kinds carried in rsp_tuser
   localparam logic [1:0] KIND_RELEASE = 2'd0;
   localparam logic [1:0] KIND_PRESS   = 2'd1;
   localparam logic [1:0] KIND_SHORT   = 2'd2;
   localparam logic [1:0] KIND_LONG    = 2'd3;

   // Hold levels
   localparam logic [2:0] LVL_NONE    = 3'd0;
   localparam logic [2:0] LVL_SHORT   = 3'd2;
   localparam logic [2:0] LVL_LONG    = 3'd3;
   localparam logic [2:0] LVL_INHIBIT = 3'd4;

   // Register indexes on the csr port
   localparam logic [2:0] REG_SHORT_HOLD  = 3'd0;
   localparam logic [2:0] REG_LONG_HOLD   = 3'd1;
   localparam logic [2:0] REG_SLOW_REPEAT = 3'd2;
   localparam logic [2:0] REG_FAST_REPEAT = 3'd3;
   localparam logic [2:0] REG_REPEAT_EN   = 3'd4;

   // Event mask bit positions, in emission order
   localparam int EV_PRESS   = 0;
   localparam int EV_HOLD    = 1;
   localparam int EV_REPEAT  = 2;
   localparam int EV_RELEASE = 3;
   localparam int EV_COUNT   = 4;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [15:0] short_hold_ms;
      logic [15:0] long_hold_ms;
      logic [15:0] slow_repeat_ms;
      logic [15:0] fast_repeat_ms;
      logic        updown_repeat_enable;
   } bhr_cfg_type;

   typedef struct packed {
      logic [2:0]          button;
      logic                hold_long;
      logic [EV_COUNT-1:0] ev_mask;
   } bhr_entry_type;

   typedef struct packed {
      logic                 full;
      logic                 head_valid;
      logic [QCNT_BITS-1:0] count;
   } bhr_qstat_type;

endpackage

// ----- rtl/core/bhr_front.sv -----
// Front end: tracks button ownership and hold timing, classifies each sample into an event set.
module bhr_front
   import bhr_pkg::*;
#(
   parameter int TIME_BITS = 32
) (
   input  logic          clock,
   input  logic          reset,
   input  bhr_cfg_type   cfg,
   input  logic          accept,
   input  logic [1:0]    operation,
   input  logic [2:0]    button_id,
   input  logic          pressed,
   input  logic [31:0]   now_ms,
   output logic          push,
   output bhr_entry_type entry
);

   logic [2:0]           owner_ff, owner_in;
   logic [2:0]           level_ff, level_in;
   logic [TIME_BITS-1:0] ptime_ff, ptime_in;
   logic [TIME_BITS-1:0] rtime_ff, rtime_in;

   logic [TIME_BITS-1:0] now_t, ptime_eff, held, gap, interval;
   logic [2:0]           level_eff, level_after;
   logic                 is_sample, take, match, long_hit, short_hit, rep, rel, is_updown;

   always_comb begin
      now_t     = TIME_BITS'(now_ms);
      is_sample = (operation == OP_SAMPLE) && (button_id inside {[BTN_SELECT:BTN_DOWN]});
      is_updown = (button_id == BTN_UP) || (button_id == BTN_DOWN);
      take      = is_sample && (owner_ff == BTN_NONE) && pressed;
      level_eff = take ? LVL_NONE : level_ff;
      ptime_eff = take ? now_t : ptime_ff;
      match     = is_sample && pressed && (take || (owner_ff == button_id));
      held      = now_t - ptime_eff;
      long_hit  = match && (held >= TIME_BITS'(cfg.long_hold_ms)) && (level_eff < LVL_LONG);
      short_hit = match && !long_hit && (held >= TIME_BITS'(cfg.short_hold_ms))
                  && (level_eff < LVL_SHORT);
      level_after = long_hit ? LVL_LONG : (short_hit ? LVL_SHORT : level_eff);
      // a short hold restarts the repeat timer in the same sample
      gap       = short_hit ? '0 : (now_t - rtime_ff);
      interval  = (level_after == LVL_LONG) ? TIME_BITS'(cfg.fast_repeat_ms)
                                            : TIME_BITS'(cfg.slow_repeat_ms);
      rep       = match && cfg.updown_repeat_enable && is_updown
                  && (level_after >= LVL_SHORT) && (gap >= interval);
      rel       = is_sample && !pressed && (owner_ff == button_id);

      owner_in = owner_ff;
      level_in = level_ff;
      ptime_in = ptime_eff;
      rtime_in = (short_hit || rep) ? now_t : rtime_ff;
      if (operation == OP_INHIBIT) begin
         level_in = LVL_INHIBIT;
      end else if (operation == OP_STARTUP) begin
         owner_in = BTN_SELECT;
         level_in = LVL_INHIBIT;
      end else if (take) begin
         owner_in = button_id;
         level_in = level_after;
      end else if (match) begin
         level_in = level_after;
      end else if (rel) begin
         owner_in = BTN_NONE;
         level_in = LVL_NONE;
      end

      entry.button               = button_id;
      entry.hold_long            = long_hit;
      entry.ev_mask[EV_PRESS]    = take;
      entry.ev_mask[EV_HOLD]     = long_hit || short_hit;
      entry.ev_mask[EV_REPEAT]   = rep;
      entry.ev_mask[EV_RELEASE]  = rel && (level_ff < LVL_INHIBIT);
      push = accept && (|entry.ev_mask);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         owner_ff <= BTN_NONE;
         level_ff <= LVL_NONE;
         ptime_ff <= '0;
         rtime_ff <= '0;
      end else if (accept) begin
         owner_ff <= owner_in;
         level_ff <= level_in;
         ptime_ff <= ptime_in;
         rtime_ff <= rtime_in;
      end
   end

endmodule

// ----- rtl/core/bhr_queue.sv -----
// Short FIFO of classified event sets between the front and back ends.
module bhr_queue
   import bhr_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  bhr_entry_type push_entry,
   input  logic          pop,
   output bhr_entry_type head,
   output bhr_qstat_type stat
);

   bhr_entry_type        mem_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wptr_ff, wptr_in;
   logic [QPTR_BITS-1:0] rptr_ff, rptr_in;
   logic [QCNT_BITS-1:0] count_ff, count_in;

   always_comb begin
      wptr_in  = push ? wptr_ff + 1'b1 : wptr_ff;
      rptr_in  = pop  ? rptr_ff + 1'b1 : rptr_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
      head            = mem_ff[rptr_ff];
      stat.count      = count_ff;
      stat.full       = (count_ff == QCNT_BITS'(QUEUE_DEPTH));
      stat.head_valid = (count_ff != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wptr_ff] <= push_entry;
      end
   end

endmodule

// ----- rtl/core/bhr_back.sv -----
// Back end: expands the head event set into single events on a registered output.
module bhr_back
   import bhr_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  bhr_entry_type head,
   input  logic          head_valid,
   output logic          pop,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output logic [2:0]    rsp_button,
   output logic [1:0]    rsp_kind,
   output logic          rsp_last
);

   logic [EV_COUNT-1:0] done_ff, done_in;
   logic                valid_ff, valid_in;
   logic [2:0]          button_ff;
   logic [1:0]          kind_ff, kind_in;
   logic                last_ff, last_in;

   logic [EV_COUNT-1:0] remaining, pick;
   logic                load;

   always_comb begin
      load      = head_valid && (!valid_ff || rsp_ready);
      remaining = head.ev_mask & ~done_ff;
      pick      = remaining & (~remaining + 1'b1);
      last_in   = ((remaining & ~pick) == '0);
      if (pick[EV_HOLD]) begin
         kind_in = head.hold_long ? KIND_LONG : KIND_SHORT;
      end else if (pick[EV_RELEASE]) begin
         kind_in = KIND_RELEASE;
      end else begin
         kind_in = KIND_PRESS;
      end
      pop      = load && last_in;
      done_in  = done_ff;
      valid_in = valid_ff;
      if (load) begin
         done_in  = last_in ? '0 : (done_ff | pick);
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         done_ff  <= done_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         button_ff <= head.button;
         kind_ff   <= kind_in;
         last_ff   <= last_in;
      end
   end

   assign rsp_valid  = valid_ff;
   assign rsp_button = button_ff;
   assign rsp_kind   = kind_ff;
   assign rsp_last   = last_ff;

endmodule

// ----- rtl/core/button_hold_repeat_events_core.sv -----
// Top level of the button hold and auto-repeat event block.
//
// req channel: one button sample or command per transaction. req_tuser holds the
// operation (sample, inhibit, startup claim); req_tdata holds button id, level and
// the millisecond timestamp. rsp channel: one event per transaction, button in
// rsp_tdata, event kind in rsp_tuser, rsp_tlast on the final event of a sample.
// A sample yields zero to three events; commands yield none.
// The front end classifies a sample in the cycle it is accepted, so a new sample
// can be taken every cycle while the four-entry event queue has room. The back
// end sends one event per cycle while the receiver is ready; with the queue and
// output idle, a sample passes through the queue entry and then the output
// register before rsp_tvalid rises; the single output register sets the event rate.
// When the receiver stalls, the output register holds, the queue fills and req_tready
// drops once it is full. Reset (synchronous) clears ownership, hold level and both
// timestamps, empties the queue and restores the register defaults. The user must
// make csr writes only while idle; the block itself does not enforce this.
module button_hold_repeat_events_core
   import bhr_pkg::*;
#(
   parameter int TIME_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // button_id[2:0], pressed[3], now_ms[35:4], zero pad
   input  logic [1:0]  req_tuser,   // operation[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // event_button[2:0], zero pad
   output logic [1:0]  rsp_tuser,   // event_kind[1:0]
   output logic        rsp_tlast,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   bhr_cfg_type   cfg_ff, cfg_in;
   bhr_entry_type push_entry, head;
   bhr_qstat_type qstat;
   logic          accept, push, pop;
   logic [2:0]    rsp_button;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            REG_SHORT_HOLD:  cfg_in.short_hold_ms        = csr_wdata;
            REG_LONG_HOLD:   cfg_in.long_hold_ms         = csr_wdata;
            REG_SLOW_REPEAT: cfg_in.slow_repeat_ms       = csr_wdata;
            REG_FAST_REPEAT: cfg_in.fast_repeat_ms       = csr_wdata;
            REG_REPEAT_EN:   cfg_in.updown_repeat_enable = csr_wdata[0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.short_hold_ms        <= 16'd1000;
         cfg_ff.long_hold_ms         <= 16'd3000;
         cfg_ff.slow_repeat_ms       <= 16'd125;
         cfg_ff.fast_repeat_ms       <= 16'd20;
         cfg_ff.updown_repeat_enable <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_tready = !qstat.full;
   assign accept     = req_tvalid && req_tready;

   bhr_front #(
      .TIME_BITS (TIME_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .accept    (accept),
      .operation (req_tuser),
      .button_id (req_tdata[2:0]),
      .pressed   (req_tdata[3]),
      .now_ms    (req_tdata[35:4]),
      .push      (push),
      .entry     (push_entry)
   );

   bhr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .stat       (qstat)
   );

   bhr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .head_valid (qstat.head_valid),
      .pop        (pop),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_button (rsp_button),
      .rsp_kind   (rsp_tuser),
      .rsp_last   (rsp_tlast)
   );

   assign rsp_tdata = {5'd0, rsp_button};

   // never pop an empty queue
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> qstat.head_valid)
      else $error("event queue popped while empty");

   // never push into a full queue
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push |-> !qstat.full)
      else $error("event queue pushed while full");

   // a queued event set shows up as queue occupancy next cycle
   a_push_visible: assert property (@(posedge clock) disable iff (reset)
      push |=> qstat.head_valid)
      else $error("pushed event set missing from queue");

   // the last event of a set leaves the queue when it is loaded
   a_last_pops: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast && !$past(rsp_tvalid && !rsp_tready) && !$past(reset))
      |-> $past(pop))
      else $error("final event loaded without releasing its queue entry");

endmodule
